// ===== src/mde_pkg.sv =====
// ----------------------------------------------------------------------------
// mde_pkg
// shared types, register codes and the min/max select function for the
// 5x5 erode/dilate filter
// ----------------------------------------------------------------------------
package mde_pkg;

  typedef enum logic [2:0] {
    REG_MORPH_OP      = 3'd0,
    REG_KERNEL_SHAPE  = 3'd1,
    REG_ELEM_TYPE     = 3'd2,
    REG_CHANNEL_COUNT = 3'd3,
    REG_IMAGE_WIDTH   = 3'd4,
    REG_IMAGE_HEIGHT  = 3'd5
  } reg_idx_t;

  localparam logic [1:0] SHAPE_CROSS   = 2'd1;
  localparam logic [1:0] SHAPE_ELLIPSE = 2'd2;
  localparam logic [1:0] ET_U8         = 2'd0;
  localparam logic [1:0] ET_S16        = 2'd2;

  typedef struct packed {
    logic        op;
    logic [1:0]  shape;
    logic [1:0]  etype;
    logic [1:0]  chans;
    logic [12:0] width;
    logic [15:0] height;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic emit;
    logic last;
    logic fend;
  } step_t;

  function automatic logic [15:0] pick(input logic [15:0] a, input logic [15:0] b,
                                       input logic dil, input logic [15:0] flip);
    logic [15:0] ka;
    logic [15:0] kb;
    ka = a ^ flip;
    kb = b ^ flip;
    if (dil) begin
      return (kb > ka) ? b : a;
    end else begin
      return (kb < ka) ? b : a;
    end
  endfunction

endpackage

// ===== src/mde_fifo.sv =====
// ----------------------------------------------------------------------------
// mde_fifo
// small show-ahead register queue with occupancy count
// ----------------------------------------------------------------------------
module mde_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic                       pop,
  input  logic [W-1:0]               din,
  output logic [W-1:0]               dout,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic                       empty
);
  localparam int PTW = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);

  logic [W-1:0]   mem [DEPTH];
  logic [PTW-1:0] wr_r;
  logic [PTW-1:0] rd_r;
  logic [CW-1:0]  cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + PTW'(1);
      end
      if (pop) begin
        rd_r <= rd_r + PTW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= din;
    end
  end

  assign dout  = mem[rd_r];
  assign count = cnt_r;
  assign empty = (cnt_r == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> cnt_r != CW'(DEPTH))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("queue underflow");

endmodule

// ===== src/mde_front.sv =====
// ----------------------------------------------------------------------------
// mde_front
// pixel intake: raster position, four line buffers, column assembly with
// edge replication and per-column min/max reductions
// ----------------------------------------------------------------------------
module mde_front
  import mde_pkg::*;
#(
  parameter int MAX_WIDTH    = 4096,
  parameter int SAMPLE_BITS  = 16,
  parameter int MAX_CHANNELS = 3
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  cfg_t                                      cfg,
  input  logic                                      acc,
  input  logic [15:0]                               smp [3],
  output logic                                      q_push,
  output logic [3*SAMPLE_BITS*MAX_CHANNELS+$bits(step_t)-1:0] q_data,
  output logic [1:0]                                inflight
);
  localparam int LW = SAMPLE_BITS;
  localparam int PW = LW * MAX_CHANNELS;
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = AW + 1;
  localparam logic [15:0] SIGN_BIT = 16'(1) << (LW - 1);

  logic [AW-1:0] col_r;
  logic [16:0]   row_r;
  logic [WW-1:0] w_eff;
  logic [15:0]   h_eff;
  logic          last_col;
  logic          last_row;
  logic [LW-1:0] lane_mask;
  logic [PW-1:0] pix;
  logic [16:0]   k [5];
  logic [4:0]    use_pix;
  logic [1:0]    bsel [5];
  logic [PW-1:0] bq [4];

  logic          v1_r;
  logic [PW-1:0] pix1_r;
  logic [4:0]    use1_r;
  logic [1:0]    bsel1_r [5];
  step_t         st1_r;
  logic [PW-1:0] col1 [5];

  logic          v2_r;
  logic [PW-1:0] col2_r [5];
  step_t         st2_r;
  logic [PW-1:0] red_f;
  logic [PW-1:0] red_m;
  logic [PW-1:0] red_c;
  logic [15:0]   flip;

  always_comb begin
    if (cfg.width < 13'd3) begin
      w_eff = WW'(3);
    end else if (15'(cfg.width) > 15'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg.width);
    end
    h_eff     = (cfg.height == 16'd0) ? 16'd1 : cfg.height;
    last_col  = (WW'(col_r) + WW'(1)) >= w_eff;
    last_row  = row_r >= (17'(h_eff) + 17'd1);
    lane_mask = (cfg.etype == ET_U8) ? LW'(16'h00FF) : {LW{1'b1}};
    flip      = (cfg.etype == ET_S16) ? SIGN_BIT : 16'd0;
  end

  for (genvar ch = 0; ch < MAX_CHANNELS; ch++) begin : g_pix
    assign pix[ch*LW +: LW] = smp[ch][LW-1:0] & lane_mask;
  end

  // source row of each window row, clamped to the frame
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      if ((18'(row_r) + 18'(i)) < 18'd4) begin
        k[i] = 17'd0;
      end else begin
        k[i] = 17'(18'(row_r) + 18'(i) - 18'd4);
      end
      if (k[i] > (17'(h_eff) - 17'd1)) begin
        k[i] = 17'(h_eff) - 17'd1;
      end
      use_pix[i] = (k[i] == row_r);
      bsel[i]    = k[i][1:0];
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [PW-1:0] mem [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (acc) begin
        if (row_r[1:0] == 2'(b)) begin
          mem[col_r] <= pix;
        end
        bq[b] <= mem[col_r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
    end else begin
      v1_r <= acc;
      v2_r <= v1_r;
      if (acc) begin
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? 17'd0 : row_r + 17'd1;
        end else begin
          col_r <= col_r + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pix1_r     <= pix;
      use1_r     <= use_pix;
      bsel1_r    <= bsel;
      st1_r.load <= (col_r == '0);
      st1_r.emit <= (row_r >= 17'd2) && (col_r >= AW'(2));
      st1_r.last <= last_col;
      st1_r.fend <= last_row;
    end
    if (v1_r) begin
      col2_r <= col1;
      st2_r  <= st1_r;
    end
  end

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      col1[i] = use1_r[i] ? pix1_r : bq[bsel1_r[i]];
    end
  end

  for (genvar ch = 0; ch < MAX_CHANNELS; ch++) begin : g_red
    logic [15:0] v [5];
    logic [15:0] m3;
    logic [15:0] f5;
    always_comb begin
      for (int i = 0; i < 5; i++) begin
        v[i] = 16'(col2_r[i][ch*LW +: LW]);
      end
      m3 = pick(pick(v[1], v[2], cfg.op, flip), v[3], cfg.op, flip);
      f5 = pick(pick(m3, v[0], cfg.op, flip), v[4], cfg.op, flip);
    end
    assign red_f[ch*LW +: LW] = f5[LW-1:0];
    assign red_m[ch*LW +: LW] = m3[LW-1:0];
    assign red_c[ch*LW +: LW] = v[2][LW-1:0];
  end

  assign q_push   = v2_r;
  assign q_data   = {st2_r, red_f, red_m, red_c};
  assign inflight = 2'(v1_r) + 2'(v2_r);

endmodule

// ===== src/mde_back.sv =====
// ----------------------------------------------------------------------------
// mde_back
// window of column reductions, right-border replication and final
// min/max across the structuring element
// ----------------------------------------------------------------------------
module mde_back
  import mde_pkg::*;
#(
  parameter int SAMPLE_BITS  = 16,
  parameter int MAX_CHANNELS = 3,
  parameter int OD           = 4
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  cfg_t                                      cfg,
  input  logic                                      q_empty,
  input  logic [3*SAMPLE_BITS*MAX_CHANNELS+$bits(step_t)-1:0] q_data,
  output logic                                      q_pop,
  input  logic [$clog2(OD+1)-1:0]                   o_count,
  output logic                                      o_push,
  output logic [49:0]                               o_data
);
  localparam int LW  = SAMPLE_BITS;
  localparam int PW  = LW * MAX_CHANNELS;
  localparam int OCW = $clog2(OD + 1);
  localparam logic [15:0] SIGN_BIT = 16'(1) << (LW - 1);

  step_t         st;
  logic [PW-1:0] nf;
  logic [PW-1:0] nm;
  logic [PW-1:0] nc;
  logic          step;
  logic [1:0]    rep_r;
  logic [1:0]    rep_nxt;
  logic          emit_now;
  logic          re_now;
  logic          fe_now;
  logic [PW-1:0] wf_r [5];
  logic [PW-1:0] wm_r [5];
  logic [PW-1:0] wc_r [5];
  logic          b1_v_r;
  logic          b1_re_r;
  logic          b1_fe_r;
  logic [15:0]   flip;
  logic [1:0]    used;
  logic [15:0]   res [3];

  assign st = step_t'(q_data[3*PW +: $bits(step_t)]);
  assign nf = q_data[2*PW +: PW];
  assign nm = q_data[PW +: PW];
  assign nc = q_data[0 +: PW];

  assign step = !q_empty && ((OCW+1)'(o_count) + (OCW+1)'(b1_v_r) < (OCW+1)'(OD));

  always_comb begin
    q_pop    = 1'b0;
    rep_nxt  = rep_r;
    emit_now = 1'b0;
    re_now   = 1'b0;
    fe_now   = 1'b0;
    if (step) begin
      emit_now = st.emit;
      if (st.emit && st.last) begin
        if (rep_r == 2'd2) begin
          q_pop   = 1'b1;
          rep_nxt = 2'd0;
          re_now  = 1'b1;
          fe_now  = st.fend;
        end else begin
          rep_nxt = rep_r + 2'd1;
        end
      end else begin
        q_pop = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_r  <= 2'd0;
      b1_v_r <= 1'b0;
    end else begin
      rep_r  <= rep_nxt;
      b1_v_r <= step && emit_now;
    end
  end

  always_ff @(posedge clk) begin
    b1_re_r <= re_now;
    b1_fe_r <= fe_now;
    if (step) begin
      if (st.load) begin
        for (int j = 0; j < 5; j++) begin
          wf_r[j] <= nf;
          wm_r[j] <= nm;
          wc_r[j] <= nc;
        end
      end else begin
        for (int j = 0; j < 4; j++) begin
          wf_r[j] <= wf_r[j+1];
          wm_r[j] <= wm_r[j+1];
          wc_r[j] <= wc_r[j+1];
        end
        wf_r[4] <= nf;
        wm_r[4] <= nm;
        wc_r[4] <= nc;
      end
    end
  end

  always_comb begin
    flip = (cfg.etype == ET_S16) ? SIGN_BIT : 16'd0;
    if (cfg.chans == 2'd0) begin
      used = 2'd1;
    end else if (cfg.chans > 2'(MAX_CHANNELS)) begin
      used = 2'(MAX_CHANNELS);
    end else begin
      used = cfg.chans;
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_out
    if (ch < MAX_CHANNELS) begin : g_used
      logic [15:0] s [5];
      logic [15:0] r;
      always_comb begin
        for (int j = 0; j < 5; j++) begin
          if (j == 2) begin
            s[j] = 16'(wf_r[j][ch*LW +: LW]);
          end else begin
            case (cfg.shape)
              SHAPE_CROSS:   s[j] = 16'(wc_r[j][ch*LW +: LW]);
              SHAPE_ELLIPSE: s[j] = 16'(wm_r[j][ch*LW +: LW]);
              default:       s[j] = 16'(wf_r[j][ch*LW +: LW]);
            endcase
          end
        end
        r = pick(pick(pick(s[0], s[1], cfg.op, flip), pick(s[3], s[4], cfg.op, flip),
                      cfg.op, flip), s[2], cfg.op, flip);
      end
      assign res[ch] = (2'(ch) < used) ? r : 16'd0;
    end else begin : g_none
      assign res[ch] = 16'd0;
    end
  end

  assign o_push = b1_v_r;
  assign o_data = {b1_re_r, b1_fe_r, res[2], res[1], res[0]};

  a_rep_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    rep_r != 2'd0 |-> !q_empty)
    else $error("border repeat without queued column");

  a_rep_holds_entry: assert property (@(posedge clk) disable iff (!rst_n)
    step && rep_r != 2'd2 && st.emit && st.last |-> !q_pop)
    else $error("column released before border repeats");

endmodule

// ===== src/morph_5x5_erode_dilate.sv =====
// throughput: one pixel per clock in while full is low; each output row needs extra border-repeat
//   steps in the back end, so a steady stream stalls the input once the 8-entry queue is full
// reset: synchronous active low; registers return to their defaults, positions to zero,
//   line buffers are not cleared
// ----------------------------------------------------------------------------
// morph_5x5_erode_dilate
// 5x5 erode/dilate over a raster pixel stream with replicated borders
// ----------------------------------------------------------------------------
module morph_5x5_erode_dilate
  import mde_pkg::*;
#(
  parameter int MAX_WIDTH    = 4096,
  parameter int SAMPLE_BITS  = 16,
  parameter int MAX_CHANNELS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [15:0] in_sample0,
  input  logic [15:0] in_sample1,
  input  logic [15:0] in_sample2,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] out_out0,
  output logic [15:0] out_out1,
  output logic [15:0] out_out2,
  output logic        out_row_end,
  output logic        out_frame_end
);
  localparam int PW     = SAMPLE_BITS * MAX_CHANNELS;
  localparam int QW     = 3 * PW + $bits(step_t);
  localparam int QDEPTH = 8;
  localparam int QCW    = $clog2(QDEPTH + 1);
  localparam int OD     = 4;
  localparam int OCW    = $clog2(OD + 1);

  cfg_t           cfg_r;
  logic           acc;
  logic [15:0]    smp [3];
  logic           q_push;
  logic [QW-1:0]  q_din;
  logic [QW-1:0]  q_dout;
  logic [QCW-1:0] q_count;
  logic           q_empty;
  logic           q_pop;
  logic [1:0]     inflight;
  logic           o_push;
  logic [49:0]    o_din;
  logic [49:0]    o_dout;
  logic [OCW-1:0] o_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.op     <= 1'b0;
      cfg_r.shape  <= 2'd0;
      cfg_r.etype  <= 2'd0;
      cfg_r.chans  <= 2'd1;
      cfg_r.width  <= 13'd640;
      cfg_r.height <= 16'd480;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_MORPH_OP:      cfg_r.op     <= cfg_data[0];
        REG_KERNEL_SHAPE:  cfg_r.shape  <= cfg_data[1:0];
        REG_ELEM_TYPE:     cfg_r.etype  <= cfg_data[1:0];
        REG_CHANNEL_COUNT: cfg_r.chans  <= cfg_data[1:0];
        REG_IMAGE_WIDTH:   cfg_r.width  <= cfg_data[12:0];
        REG_IMAGE_HEIGHT:  cfg_r.height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign full = ((QCW+1)'(q_count) + (QCW+1)'(inflight)) >= (QCW+1)'(QDEPTH);
  assign acc  = push && !full;
  assign smp  = '{in_sample0, in_sample1, in_sample2};

  mde_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .acc     (acc),
    .smp     (smp),
    .q_push  (q_push),
    .q_data  (q_din),
    .inflight(inflight)
  );

  mde_fifo #(
    .W    (QW),
    .DEPTH(QDEPTH)
  ) u_colq (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .pop  (q_pop),
    .din  (q_din),
    .dout (q_dout),
    .count(q_count),
    .empty(q_empty)
  );

  mde_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_CHANNELS(MAX_CHANNELS),
    .OD          (OD)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .q_empty(q_empty),
    .q_data (q_dout),
    .q_pop  (q_pop),
    .o_count(o_count),
    .o_push (o_push),
    .o_data (o_din)
  );

  mde_fifo #(
    .W    (50),
    .DEPTH(OD)
  ) u_outq (
    .clk  (clk),
    .rst_n(rst_n),
    .push (o_push),
    .pop  (pop && !empty),
    .din  (o_din),
    .dout (o_dout),
    .count(o_count),
    .empty(empty)
  );

  assign out_row_end   = o_dout[49];
  assign out_frame_end = o_dout[48];
  assign out_out2      = o_dout[47:32];
  assign out_out1      = o_dout[31:16];
  assign out_out0      = o_dout[15:0];

endmodule

// ===== test/tb_morph_5x5_erode_dilate.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_morph_5x5_erode_dilate
// Drives raster frames through the 5x5 erode/dilate filter under a range of
// register settings, border cases and random flow control. A behavioral
// filter in the bench predicts every output pixel, and the monitor checks
// each one in order.
// ----------------------------------------------------------------------------
module tb_morph_5x5_erode_dilate;
  import mde_pkg::*;

  typedef struct {
    logic [15:0] s0, s1, s2;
  } pixel_t;

  typedef struct {
    logic [15:0] o0, o1, o2;
    logic        re, fe;
  } filt_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        push = 0;
  logic        full;
  logic [15:0] in_sample0 = '0, in_sample1 = '0, in_sample2 = '0;
  logic        empty;
  logic        pop = 0;
  logic [15:0] out_out0, out_out1, out_out2;
  logic        out_row_end, out_frame_end;

  morph_5x5_erode_dilate uut (.*);

  always #4 clk = ~clk;

  // filter state mirrored in the bench
  logic [47:0] lines [4*4096];
  logic [47:0] win [25];
  int unsigned cpos, rpos;
  logic        m_op;
  logic [1:0]  m_shape, m_etype, m_chans;
  logic [12:0] m_width;
  logic [15:0] m_rows;

  pixel_t pend_pix[$];
  filt_t  filt_q[$];
  int     fails = 0;
  bit     no_gaps = 1;
  int     tx_gap = 0;
  int     rx_gap = 0;
  int     rx_hold = 0;
  bit     long_done = 0;

  function automatic int eff_width();
    return (m_width < 3) ? 3 : (m_width > 4096) ? 4096 : int'(m_width);
  endfunction

  function automatic int eff_height();
    return (m_rows == 0) ? 1 : int'(m_rows);
  endfunction

  function automatic logic [15:0] order_key(logic [15:0] v);
    return (m_etype == ET_S16) ? (v ^ 16'h8000) : v;
  endfunction

  function automatic bit in_elem(int i, int j);
    if (m_shape == SHAPE_CROSS) return i == 2 || j == 2;
    if (m_shape == SHAPE_ELLIPSE) return (i >= 1 && i <= 3) || j == 2;
    return 1;
  endfunction

  function automatic void shift_win(logic [47:0] col [5]);
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 4; j++) win[i*5+j] = win[i*5+j+1];
      win[i*5+4] = col[i];
    end
  endfunction

  function automatic void add_filtered(logic re, logic fe);
    filt_t f;
    logic [15:0] best, v, res [3];
    int nch;
    nch = (m_chans == 0) ? 1 : int'(m_chans);
    for (int ch = 0; ch < 3; ch++) begin
      best = '0;
      if (ch < nch) begin
        best = win[12][16*ch +: 16];
        for (int i = 0; i < 5; i++)
          for (int j = 0; j < 5; j++)
            if (in_elem(i, j)) begin
              v = win[i*5+j][16*ch +: 16];
              if (m_op ? (order_key(v) > order_key(best)) : (order_key(v) < order_key(best)))
                best = v;
            end
      end
      res[ch] = best;
    end
    f.o0 = res[0]; f.o1 = res[1]; f.o2 = res[2]; f.re = re; f.fe = fe;
    filt_q.push_back(f);
  endfunction

  function automatic void filter_pixel(pixel_t p);
    int w, h, c, r, k;
    logic [15:0] m;
    logic [47:0] pix;
    logic [47:0] col [5];
    bit lastc, lastr;
    w = eff_width();
    h = eff_height();
    c = (cpos >= 4096) ? 4095 : int'(cpos);
    r = int'(rpos);
    m = (m_etype == ET_U8) ? 16'h00ff : 16'hffff;
    pix = {p.s2 & m, p.s1 & m, p.s0 & m};
    for (int i = 0; i < 5; i++) begin
      k = r - 4 + i;
      if (k < 0) k = 0;
      if (k > h - 1) k = h - 1;
      col[i] = (k == r) ? pix : lines[(k & 3)*4096 + c];
    end
    lines[(r & 3)*4096 + c] = pix;
    if (c == 0) begin
      for (int i = 0; i < 25; i++) win[i] = col[i/5];
    end else begin
      shift_win(col);
    end
    lastc = c >= w - 1;
    lastr = r >= h + 1;
    if (r >= 2 && c >= 2) begin
      add_filtered(0, 0);
      if (lastc) begin
        for (int i = 0; i < 5; i++) col[i] = win[i*5+4];
        shift_win(col);
        add_filtered(0, 0);
        shift_win(col);
        add_filtered(1, lastr);
      end
    end
    if (lastc) begin
      cpos = 0;
      rpos = lastr ? 0 : r + 1;
    end else begin
      cpos = c + 1;
    end
  endfunction

  function automatic int draw_gap();
    int d;
    if (no_gaps) return 0;
    d = $urandom_range(0, 19);
    if (d < 12) return 0;
    if (d < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver
  always @(posedge clk) begin
    pixel_t p;
    if (!rst_n) begin
      push <= 0;
    end else if (!(push && full)) begin
      if (push) filter_pixel('{in_sample0, in_sample1, in_sample2});
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        push <= 0;
      end else if (pend_pix.size() > 0) begin
        p = pend_pix.pop_front();
        in_sample0 <= p.s0;
        in_sample1 <= p.s1;
        in_sample2 <= p.s2;
        push <= 1;
        tx_gap <= draw_gap();
      end else begin
        push <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    filt_t f;
    if (!rst_n) begin
      pop <= 0;
    end else begin
      if (pop && !empty) begin
        if (filt_q.size() == 0) begin
          $error("unexpected transaction out0=%h", out_out0);
          fails++;
        end else begin
          f = filt_q.pop_front();
          if (out_out0 !== f.o0) begin
            $error("out0 exp %h got %h", f.o0, out_out0); fails++;
          end
          if (out_out1 !== f.o1) begin
            $error("out1 exp %h got %h", f.o1, out_out1); fails++;
          end
          if (out_out2 !== f.o2) begin
            $error("out2 exp %h got %h", f.o2, out_out2); fails++;
          end
          if (out_row_end !== f.re) begin
            $error("row_end exp %b got %b", f.re, out_row_end); fails++;
          end
          if (out_frame_end !== f.fe) begin
            $error("frame_end exp %b got %b", f.fe, out_frame_end); fails++;
          end
        end
      end
      if (!long_done && pend_pix.size() > 24 && filt_q.size() > 0) begin
        long_done <= 1;
        rx_hold <= 400;
        pop <= 0;
      end else if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        pop <= 0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        pop <= 0;
      end else begin
        pop <= 1;
        rx_gap <= draw_gap();
      end
    end
  end

  task automatic wait_idle();
    while (pend_pix.size() > 0 || push || filt_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      REG_MORPH_OP:      m_op = v[0];
      REG_KERNEL_SHAPE:  m_shape = v[1:0];
      REG_ELEM_TYPE:     m_etype = v[1:0];
      REG_CHANNEL_COUNT: m_chans = v[1:0];
      REG_IMAGE_WIDTH:   m_width = v[12:0];
      REG_IMAGE_HEIGHT:  m_rows = v;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_all(int op, int sh, int et, int ch, int w, int h);
    write_reg(REG_MORPH_OP, 16'(op));
    write_reg(REG_KERNEL_SHAPE, 16'(sh));
    write_reg(REG_ELEM_TYPE, 16'(et));
    write_reg(REG_CHANNEL_COUNT, 16'(ch));
    write_reg(REG_IMAGE_WIDTH, 16'(w));
    write_reg(REG_IMAGE_HEIGHT, 16'(h));
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'h8000;
      3: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_pixels(int n);
    for (int i = 0; i < n; i++)
      pend_pix.push_back('{rand_sample(), rand_sample(), rand_sample()});
  endtask

  int sent;

  initial begin
    m_op = 0; m_shape = 0; m_etype = 0; m_chans = 1; m_width = 640; m_rows = 480;
    cpos = 0; rpos = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    repeat (2) @(posedge clk);

    // directed: narrowest single-row frame with extreme samples
    set_all(0, 0, 0, 1, 3, 1);
    pend_pix.push_back('{16'h0000, 16'hffff, 16'h8000});
    pend_pix.push_back('{16'hffff, 16'h0000, 16'h7fff});
    pend_pix.push_back('{16'h8000, 16'h7fff, 16'h0001});
    queue_pixels(6);
    wait_idle();
    // dilate signed, three channels, cross
    set_all(1, 1, 2, 3, 3, 2);
    queue_pixels(12);
    wait_idle();

    // tall frame cut short by lowering the height between rows
    set_all(0, 2, 1, 2, 3, 16'hffff);
    queue_pixels(9);
    wait_idle();
    write_reg(REG_IMAGE_HEIGHT, 16'd1);
    queue_pixels(3);
    wait_idle();

    // out-of-range width and zero height saturate, reserved codes
    set_all(1, 3, 3, 0, 0, 0);
    queue_pixels(9);
    wait_idle();

    // receiver stalls for a long stretch to fill the block
    set_all(0, 0, 1, 3, 8, 6);
    queue_pixels(64);
    wait_idle();

    no_gaps = 0;
    sent = 0;
    while (sent < 100) begin
      int w, h;
      set_all($urandom_range(0, 1), $urandom_range(0, 3), $urandom_range(0, 3),
              $urandom_range(0, 3), $urandom_range(0, 9), $urandom_range(0, 4));
      w = eff_width();
      h = eff_height();
      queue_pixels(w * (h + 2));
      sent += w * (h + 2);
      if ($urandom_range(0, 3) == 0) no_gaps = ~no_gaps;
      wait_idle();
    end

    repeat (30) @(posedge clk);
    if (fails == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
